// ----- hdl/dbhc_pkg.sv -----
package dbhc_pkg;

    localparam int DEFAULT_PAYLOAD_COUNT_BITS = 40;

    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 32;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_BITS-1:0] REG_TYPE_A     = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TYPE_B     = 8'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_VALID_FLAGS = 8'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COMP_FLAGS = 8'd3;

    localparam logic [31:0] RESET_TYPE_A      = 32'd1;
    localparam logic [31:0] RESET_TYPE_B      = 32'd2;
    localparam logic [31:0] RESET_VALID_FLAGS = 32'd1;
    localparam logic [31:0] RESET_COMP_FLAGS  = 32'd1;

    // header byte map
    localparam logic [4:0] POS_MAGIC_LAST = 5'd3;
    localparam logic [4:0] POS_TYPE_FIRST = 5'd4;
    localparam logic [4:0] POS_TYPE_LAST  = 5'd7;
    localparam logic [4:0] POS_HLEN_LAST  = 5'd11;
    localparam logic [4:0] HDR_BASE_BYTES = 5'd12;
    localparam logic [4:0] POS_CHK_FIRST  = 5'd20;
    localparam logic [4:0] POS_FLAG_FIRST = 5'd24;
    localparam logic [4:0] POS_FLAG_LAST  = 5'd27;
    localparam logic [4:0] HDR_TOTAL      = 5'd28;

    localparam logic [31:0] HDR_LENGTH_EXPECTED = 32'd28;

    localparam logic [7:0] MAGIC_BYTES [4] = '{8'hfc, 8'h1a, 8'hb1, 8'h0b};

    localparam logic [31:0] CRC_POLY = 32'hedb88320;
    localparam logic [31:0] CRC_INIT = 32'hffffffff;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_SHORT_BUF = 2'd1,
        ST_INTEGRITY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        CAUSE_NONE    = 3'd0,
        CAUSE_SHORT   = 3'd1,
        CAUSE_MAGIC   = 3'd2,
        CAUSE_TYPE    = 3'd3,
        CAUSE_HDR_LEN = 3'd4,
        CAUSE_CRC     = 3'd5,
        CAUSE_FLAGS   = 3'd6,
        CAUSE_PLEN    = 3'd7
    } t_cause;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        t_cause      cause;
        logic [31:0] blob_type;
        logic        compressed;
        logic [63:0] body_length;
    } t_out_item;

    typedef struct packed {
        logic [31:0] accepted_type_a;
        logic [31:0] accepted_type_b;
        logic [31:0] valid_flags_mask;
        logic [31:0] compressed_flag_mask;
    } t_cfg;

    // reflected CRC-32, one byte
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'h000000, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic t_cause latch_cause(input t_cause cur, input t_cause c);
        return (cur == CAUSE_NONE) ? c : cur;
    endfunction

endpackage

// ----- hdl/dbhc_cfg.sv -----
module dbhc_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [dbhc_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [dbhc_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    output dbhc_pkg::t_cfg                      o_cfg
);
    import dbhc_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.accepted_type_a      <= RESET_TYPE_A;
            r_cfg.accepted_type_b      <= RESET_TYPE_B;
            r_cfg.valid_flags_mask     <= RESET_VALID_FLAGS;
            r_cfg.compressed_flag_mask <= RESET_COMP_FLAGS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_TYPE_A:      r_cfg.accepted_type_a      <= i_cfg_data;
                REG_TYPE_B:      r_cfg.accepted_type_b      <= i_cfg_data;
                REG_VALID_FLAGS: r_cfg.valid_flags_mask     <= i_cfg_data;
                REG_COMP_FLAGS:  r_cfg.compressed_flag_mask <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// ----- hdl/dbhc_core.sv -----
module dbhc_core #(
    parameter int PAYLOAD_COUNT_BITS = dbhc_pkg::DEFAULT_PAYLOAD_COUNT_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  dbhc_pkg::t_in_item   i_item,
    input  dbhc_pkg::t_cfg       i_cfg,
    output dbhc_pkg::t_out_item  o_result
);
    import dbhc_pkg::*;

    localparam logic [PAYLOAD_COUNT_BITS-1:0] CNT_MAX = {PAYLOAD_COUNT_BITS{1'b1}};

    logic [4:0]                    r_pos,   n_pos;
    logic [31:0]                   r_crc,   n_crc;
    logic                          r_magic, n_magic;
    logic [31:0]                   r_type,  n_type;
    logic [31:0]                   r_hlen,  n_hlen;
    logic [63:0]                   r_plen,  n_plen;
    logic [31:0]                   r_chk,   n_chk;
    logic [31:0]                   r_flag,  n_flag;
    t_cause                        r_err,   n_err;
    logic [PAYLOAD_COUNT_BITS-1:0] r_cnt,   n_cnt;

    logic [7:0] w_b;
    logic [2:0] w_plen_lane;
    t_cause     w_cause;

    assign w_b = i_item.data_byte;
    // byte 12..19 -> lane 0..7: flipping bit 2 of the position does the subtract
    assign w_plen_lane = r_pos[2:0] ^ 3'b100;

    always_comb begin
        n_pos   = r_pos;
        n_crc   = r_crc;
        n_magic = r_magic;
        n_type  = r_type;
        n_hlen  = r_hlen;
        n_plen  = r_plen;
        n_chk   = r_chk;
        n_flag  = r_flag;
        n_err   = r_err;
        n_cnt   = r_cnt;

        if (r_pos < HDR_TOTAL) begin
            n_pos = r_pos + 5'd1;
            // checksum bytes enter the CRC as zero
            n_crc = crc32_byte(r_crc,
                ((r_pos >= POS_CHK_FIRST) && (r_pos < POS_FLAG_FIRST)) ? 8'h00 : w_b);
            if (r_pos < POS_TYPE_FIRST) begin
                n_magic = r_magic & (w_b == MAGIC_BYTES[r_pos[1:0]]);
                if ((r_pos == POS_MAGIC_LAST) && !n_magic) begin
                    n_err = latch_cause(n_err, CAUSE_MAGIC);
                end
            end else if (r_pos <= POS_TYPE_LAST) begin
                n_type[8*r_pos[1:0] +: 8] = w_b;
                if ((r_pos == POS_TYPE_LAST) && (n_type != i_cfg.accepted_type_a)
                        && (n_type != i_cfg.accepted_type_b)) begin
                    n_err = latch_cause(n_err, CAUSE_TYPE);
                end
            end else if (r_pos < HDR_BASE_BYTES) begin
                n_hlen[8*r_pos[1:0] +: 8] = w_b;
                if ((r_pos == POS_HLEN_LAST) && (n_hlen != HDR_LENGTH_EXPECTED)) begin
                    n_err = latch_cause(n_err, CAUSE_HDR_LEN);
                end
            end else if (r_pos < POS_CHK_FIRST) begin
                n_plen[8*w_plen_lane +: 8] = w_b;
            end else if (r_pos < POS_FLAG_FIRST) begin
                n_chk[8*r_pos[1:0] +: 8] = w_b;
            end else begin
                n_flag[8*r_pos[1:0] +: 8] = w_b;
                if (r_pos == POS_FLAG_LAST) begin
                    if (~n_crc != r_chk) begin
                        n_err = latch_cause(n_err, CAUSE_CRC);
                    end
                    if ((n_flag & ~i_cfg.valid_flags_mask) != 32'd0) begin
                        n_err = latch_cause(n_err, CAUSE_FLAGS);
                    end
                end
            end
        end else if (r_cnt != CNT_MAX) begin
            n_cnt = r_cnt + 1'b1;
        end

        // magic and type failures outrank a short header past the base part
        if (n_pos < HDR_BASE_BYTES) begin
            w_cause = CAUSE_SHORT;
        end else if ((n_err == CAUSE_MAGIC) || (n_err == CAUSE_TYPE)) begin
            w_cause = n_err;
        end else if (n_pos < HDR_TOTAL) begin
            w_cause = CAUSE_SHORT;
        end else if (n_err != CAUSE_NONE) begin
            w_cause = n_err;
        end else if ((n_cnt == CNT_MAX) || (64'(n_cnt) != n_plen)) begin
            w_cause = CAUSE_PLEN;
        end else begin
            w_cause = CAUSE_NONE;
        end

        o_result.cause  = w_cause;
        o_result.status = (w_cause == CAUSE_NONE)  ? ST_OK :
                          (w_cause == CAUSE_SHORT) ? ST_SHORT_BUF : ST_INTEGRITY;
        o_result.blob_type      = (n_pos > POS_TYPE_LAST) ? n_type : 32'd0;
        o_result.compressed     = (n_pos >= HDR_TOTAL)
                                  && ((n_flag & i_cfg.compressed_flag_mask) != 32'd0);
        o_result.body_length    = (n_pos >= POS_CHK_FIRST) ? n_plen : 64'd0;

        if (i_item.last) begin
            n_pos   = 5'd0;
            n_crc   = CRC_INIT;
            n_magic = 1'b1;
            n_type  = 32'd0;
            n_hlen  = 32'd0;
            n_plen  = 64'd0;
            n_chk   = 32'd0;
            n_flag  = 32'd0;
            n_err   = CAUSE_NONE;
            n_cnt   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= 5'd0;
            r_crc   <= CRC_INIT;
            r_magic <= 1'b1;
            r_type  <= 32'd0;
            r_hlen  <= 32'd0;
            r_plen  <= 64'd0;
            r_chk   <= 32'd0;
            r_flag  <= 32'd0;
            r_err   <= CAUSE_NONE;
            r_cnt   <= '0;
        end else if (i_step) begin
            r_pos   <= n_pos;
            r_crc   <= n_crc;
            r_magic <= n_magic;
            r_type  <= n_type;
            r_hlen  <= n_hlen;
            r_plen  <= n_plen;
            r_chk   <= n_chk;
            r_flag  <= n_flag;
            r_err   <= n_err;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ----- hdl/delivery_blob_header_checker.sv -----
// channel | direction | handshake                | payload
// --------+-----------+--------------------------+---------------------------------
// in      | in        | i_in_valid / o_in_ready  | i_in_item  (data_byte, last)
// out     | out       | o_out_valid / i_out_ready| o_out_item (status .. body_length)
// cfg     | in        | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// One byte per cycle sustained: an input register feeds the header/CRC update, whose
// verdict on a last byte is captured in the output register when that byte advances.
// Bytes without last never wait on the output side; a last byte holds in the input
// register only while the previous verdict is still untaken.
// Reset is synchronous, active low; o_cfg_ready is always high.
module delivery_blob_header_checker #(
    parameter int PAYLOAD_COUNT_BITS = dbhc_pkg::DEFAULT_PAYLOAD_COUNT_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  dbhc_pkg::t_in_item                  i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output dbhc_pkg::t_out_item                 o_out_item,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [dbhc_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [dbhc_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import dbhc_pkg::*;

    logic      r_in_vld;
    t_in_item  r_in;
    logic      r_out_vld;
    t_out_item r_out;
    t_out_item w_result;
    t_cfg      w_cfg;
    logic      w_adv;

    dbhc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    dbhc_core #(
        .PAYLOAD_COUNT_BITS (PAYLOAD_COUNT_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_adv),
        .i_item   (r_in),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    assign w_adv      = r_in_vld && (!r_in.last || !r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || w_adv;

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv && r_in.last) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_in.last) begin
            r_out <= w_result;
        end
    end

    // a last byte must not advance over an untaken verdict
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && r_in.last && r_out_vld && !i_out_ready) |-> !w_adv)
        else $error("verdict overwritten while stalled");

    a_verdict_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in.last) |=> (o_out_valid && $past(w_result) == o_out_item))
        else $error("last byte did not produce its verdict");

    a_status_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_item.status == ST_OK) == (o_out_item.cause == CAUSE_NONE))
                     && ((o_out_item.status == ST_SHORT_BUF)
                         == (o_out_item.cause == CAUSE_SHORT)))
        else $error("status and cause disagree");

    a_non_last_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !r_in.last) |-> o_in_ready)
        else $error("non-last byte stalled");

endmodule
